// ===== hdl/ptrs_pkg.sv =====
// Shared types and constants of the periodic task release scheduler.
`timescale 1ns / 1ps

package ptrs_pkg;

    localparam int TIME_W          = 32;
    localparam int PERIOD_W        = 16;
    localparam int CNT_W           = 16;
    localparam int BACKLOG_W       = 8;
    localparam int TASK_IDX_W      = 2;
    localparam int NUM_PERIOD_REGS = 3;
    localparam int REG_IDX_W       = 2;
    localparam int ADDR_W          = 4;
    localparam int APB_DATA_W      = 32;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_PERIOD0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD2 = 2'd2;

    typedef logic [NUM_PERIOD_REGS-1:0][PERIOD_W-1:0] ptrs_period_bank_t;

    localparam ptrs_period_bank_t PERIOD_RESET = {16'd250, 16'd250, 16'd100};

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_DONE     = 2'd2,
        CMD_QUERY    = 2'd3
    } ptrs_cmd_t;

    typedef enum logic [1:0] {
        TS_BLOCKED = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2
    } ptrs_task_state_t;

    // Decoded operation handed to the task table for one beat
    typedef struct packed {
        logic                  tick_go;
        logic                  dispatch_go;
        logic                  done_go;
        logic                  query_go;
        logic [TASK_IDX_W-1:0] query_task;
    } ptrs_op_t;

    // Result fields produced by the task table
    typedef struct packed {
        logic                  status;
        logic [BACKLOG_W-1:0]  backlog;
        logic [CNT_W-1:0]      executed_count;
        logic [CNT_W-1:0]      missed_count;
        logic [TASK_IDX_W-1:0] task_index;
        logic                  task_valid;
    } ptrs_table_res_t;

endpackage

// ===== hdl/ptrs_tick_unit.sv =====
// Tick counter, heartbeat residue and release times of the periodic tasks.
`timescale 1ns / 1ps

module ptrs_tick_unit #(
    parameter int NUM_TASKS       = 3,
    parameter int HEARTBEAT_TICKS = 100
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_go,
    input  logic                                cfg_wr,
    input  logic [ptrs_pkg::REG_IDX_W-1:0]      cfg_idx,
    input  logic [ptrs_pkg::PERIOD_W-1:0]       cfg_data,
    input  ptrs_pkg::ptrs_period_bank_t         period_regs,
    output logic [NUM_TASKS-2:0]                release_mask,
    output logic                                hb_hit
);
    import ptrs_pkg::*;

    localparam int NUM_PER = NUM_TASKS - 1;
    localparam int HB_W    = $clog2(HEARTBEAT_TICKS + 1);

    logic [TIME_W-1:0] tick_count_reg;
    logic [TIME_W-1:0] tick_count_next;
    logic [HB_W-1:0]   hb_res_reg;
    logic [HB_W-1:0]   hb_res_next;
    logic [NUM_PER-1:0][TIME_W-1:0] next_release_reg;
    logic [NUM_PER-1:0][TIME_W-1:0] next_release_next;

    // Compare each periodic task's release time with the tick count
    always_comb
    begin
        for (int i = 0; i < NUM_PER; i++)
        begin
            release_mask[i] = (tick_count_reg == next_release_reg[i]);
        end
    end

    // Advance the count and the residue modulo the heartbeat interval; a count wrap restarts the residue
    always_comb
    begin
        tick_count_next = tick_count_reg + TIME_W'(1);
        if (tick_count_reg == {TIME_W{1'b1}})
        begin
            hb_res_next = '0;
        end
        else if (hb_res_reg == HB_W'(HEARTBEAT_TICKS - 1))
        begin
            hb_res_next = '0;
        end
        else
        begin
            hb_res_next = hb_res_reg + HB_W'(1);
        end
        hb_hit = (hb_res_next == '0);
    end

    // Reschedule released tasks, or load a release time from a period write
    always_comb
    begin
        next_release_next = next_release_reg;
        for (int i = 0; i < NUM_PER; i++)
        begin
            if (cfg_wr && (cfg_idx == REG_IDX_W'(i)))
            begin
                next_release_next[i] = TIME_W'(cfg_data);
            end
            else if (tick_go && release_mask[i])
            begin
                next_release_next[i] = tick_count_reg + TIME_W'(period_regs[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            hb_res_reg     <= '0;
            for (int i = 0; i < NUM_PER; i++)
            begin
                next_release_reg[i] <= TIME_W'(PERIOD_RESET[i]);
            end
        end
        else
        begin
            if (tick_go)
            begin
                tick_count_reg <= tick_count_next;
                hb_res_reg     <= hb_res_next;
            end
            next_release_reg <= next_release_next;
        end
    end

endmodule

// ===== hdl/ptrs_task_table.sv =====
// Per-task backlog, state and counters with dispatch, done and query.
`timescale 1ns / 1ps

module ptrs_task_table #(
    parameter int NUM_TASKS = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ptrs_pkg::ptrs_op_t         op,
    input  logic [NUM_TASKS-1:0]       release_mask,
    output ptrs_pkg::ptrs_table_res_t  res
);
    import ptrs_pkg::*;

    logic [NUM_TASKS-1:0][BACKLOG_W-1:0] backlog_reg, backlog_next;
    logic [NUM_TASKS-1:0][CNT_W-1:0]     missed_reg, missed_next;
    logic [NUM_TASKS-1:0][CNT_W-1:0]     executed_reg, executed_next;
    ptrs_task_state_t                    state_reg [NUM_TASKS];
    ptrs_task_state_t                    state_next [NUM_TASKS];
    logic                                run_busy_reg, run_busy_next;
    logic [TASK_IDX_W-1:0]               run_idx_reg, run_idx_next;
    logic [NUM_TASKS-1:0]                running_vec;

    always_comb
    begin
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            running_vec[i] = (state_reg[i] == TS_RUNNING);
        end
    end

    always_comb
    begin
        logic found;
        found         = 1'b0;
        backlog_next  = backlog_reg;
        missed_next   = missed_reg;
        executed_next = executed_reg;
        state_next    = state_reg;
        run_busy_next = run_busy_reg;
        run_idx_next  = run_idx_reg;
        res           = '0;

        // Release: bump backlog, make ready, count a miss when jobs pile up
        if (op.tick_go)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (release_mask[i])
                begin
                    if (backlog_reg[i] != {BACKLOG_W{1'b1}})
                    begin
                        backlog_next[i] = backlog_reg[i] + BACKLOG_W'(1);
                    end
                    if (state_reg[i] != TS_RUNNING)
                    begin
                        state_next[i] = TS_READY;
                    end
                    if ((backlog_next[i] > BACKLOG_W'(1)) &&
                        (missed_reg[i] != {CNT_W{1'b1}}))
                    begin
                        missed_next[i] = missed_reg[i] + CNT_W'(1);
                    end
                end
            end
        end

        // Dispatch the lowest-index ready task when nothing runs
        if (op.dispatch_go && !run_busy_reg)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (!found && (state_reg[i] == TS_READY))
                begin
                    found          = 1'b1;
                    state_next[i]  = TS_RUNNING;
                    run_busy_next  = 1'b1;
                    run_idx_next   = TASK_IDX_W'(i);
                    res.task_valid = 1'b1;
                    res.task_index = TASK_IDX_W'(i);
                end
            end
        end

        // Retire the running job and report its counters, or flag the status when nothing runs
        if (op.done_go)
        begin
            if (!run_busy_reg)
            begin
                res.status = 1'b1;
            end
            else
            begin
                run_busy_next = 1'b0;
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    if (run_idx_reg == TASK_IDX_W'(i))
                    begin
                        if (executed_reg[i] != {CNT_W{1'b1}})
                        begin
                            executed_next[i] = executed_reg[i] + CNT_W'(1);
                        end
                        if (backlog_reg[i] != '0)
                        begin
                            backlog_next[i] = backlog_reg[i] - BACKLOG_W'(1);
                        end
                        state_next[i] = (backlog_next[i] != '0) ? TS_READY : TS_BLOCKED;
                        res.task_index     = TASK_IDX_W'(i);
                        res.missed_count   = missed_reg[i];
                        res.executed_count = executed_next[i];
                        res.backlog        = backlog_next[i];
                    end
                end
            end
        end

        // Read one task's counters; an absent task reads as zero
        if (op.query_go)
        begin
            res.task_index = op.query_task;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (op.query_task == TASK_IDX_W'(i))
                begin
                    res.missed_count   = missed_reg[i];
                    res.executed_count = executed_reg[i];
                    res.backlog        = backlog_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                backlog_reg[i]  <= BACKLOG_W'(1);
                missed_reg[i]   <= '0;
                executed_reg[i] <= '0;
                state_reg[i]    <= TS_READY;
            end
            run_busy_reg <= 1'b0;
            run_idx_reg  <= '0;
        end
        else
        begin
            backlog_reg  <= backlog_next;
            missed_reg   <= missed_next;
            executed_reg <= executed_next;
            state_reg    <= state_next;
            run_busy_reg <= run_busy_next;
            run_idx_reg  <= run_idx_next;
        end
    end

    // At most one task holds the processor
    a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(running_vec))
        else $error("more than one task marked running");

    // The busy flag agrees with the task states
    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        run_busy_reg == (|running_vec))
        else $error("running flag disagrees with task states");

    // The recorded running index points at the running task
    a_idx_match: assert property (@(posedge clk) disable iff (!rst_n)
        run_busy_reg |-> (|(running_vec & (NUM_TASKS'(1) << run_idx_reg))))
        else $error("running index does not point at a running task");

endmodule

// ===== hdl/periodic_task_release_scheduler.sv =====
// A beat accepted on the input is held in the input register, then registered on m_tdata.
// One command per cycle while the result side does not stall; the input and result registers set the pace.
// The input stalls only while both registers hold a beat and the result is not taken.
// Reset (rst_n low, asynchronous): tick count zero, periods 100/250/250,
// all tasks ready with one job waiting, counters zero, no task running.
`timescale 1ns / 1ps

module periodic_task_release_scheduler #(
    parameter int NUM_TASKS       = 3,
    parameter int HEARTBEAT_TICKS = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptrs_pkg::ADDR_W-1:0]        paddr,
    input  logic [ptrs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ptrs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // Command stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // event_release, ui_hold, query_task[1:0], zeros
    input  logic [1:0]                         s_tuser,  // cmd[1:0]
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [47:0]                        m_tdata   // task_valid, task_index[1:0], heartbeat,
                                                          // missed_count[15:0], executed_count[15:0],
                                                          // backlog[7:0], status, zeros
);
    import ptrs_pkg::*;

    localparam int NUM_PER = NUM_TASKS - 1;

    ptrs_period_bank_t     period_reg;
    logic                  reg_wr;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  reg_idx;

    logic                  in_valid_reg;
    ptrs_cmd_t             in_cmd_reg;
    logic                  in_ev_reg;
    logic                  in_hold_reg;
    logic [TASK_IDX_W-1:0] in_q_reg;

    logic                  advance;
    logic                  tick_go;
    ptrs_op_t              op;
    logic [NUM_PER-1:0]    per_release;
    logic [NUM_TASKS-1:0]  release_mask;
    logic                  hb_hit;
    ptrs_table_res_t       tbl_res;

    logic                  m_tvalid_reg;
    logic [47:0]           m_tdata_reg;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign reg_wr  = psel && penable && pwrite && pready;
    assign cfg_wr  = reg_wr && (reg_idx != REG_IDX_W'(NUM_PERIOD_REGS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (reg_wr)
        begin
            unique case (reg_idx)
                REG_PERIOD0: period_reg[0] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD1: period_reg[1] <= pwdata[PERIOD_W-1:0];
                REG_PERIOD2: period_reg[2] <= pwdata[PERIOD_W-1:0];
                default:     period_reg    <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PERIOD0: prdata = APB_DATA_W'(period_reg[0]);
            REG_PERIOD1: prdata = APB_DATA_W'(period_reg[1]);
            REG_PERIOD2: prdata = APB_DATA_W'(period_reg[2]);
            default:     prdata = '0;
        endcase
    end

    // Input register: take a beat when empty or when it moves on
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= ptrs_cmd_t'(s_tuser);
            in_ev_reg   <= s_tdata[0];
            in_hold_reg <= s_tdata[1];
            in_q_reg    <= s_tdata[3:2];
        end
    end

    // Decode the held command
    always_comb
    begin
        op            = '0;
        op.query_task = in_q_reg;
        unique case (in_cmd_reg)
            CMD_TICK:     op.tick_go     = advance && !in_hold_reg;
            CMD_DISPATCH: op.dispatch_go = advance;
            CMD_DONE:     op.done_go     = advance;
            CMD_QUERY:    op.query_go    = advance;
            default:      op            = '0;
        endcase
    end

    assign tick_go      = op.tick_go;
    assign release_mask = {in_ev_reg, per_release};

    ptrs_tick_unit #(
        .NUM_TASKS       (NUM_TASKS),
        .HEARTBEAT_TICKS (HEARTBEAT_TICKS)
    ) u_tick (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_go      (tick_go),
        .cfg_wr       (cfg_wr),
        .cfg_idx      (reg_idx),
        .cfg_data     (pwdata[PERIOD_W-1:0]),
        .period_regs  (period_reg),
        .release_mask (per_release),
        .hb_hit       (hb_hit)
    );

    ptrs_task_table #(
        .NUM_TASKS (NUM_TASKS)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .release_mask (release_mask),
        .res          (tbl_res)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= {3'b000, tbl_res.status, tbl_res.backlog,
                            tbl_res.executed_count, tbl_res.missed_count,
                            tick_go && hb_hit, tbl_res.task_index, tbl_res.task_valid};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The input side stalls only when both registers are full and the sink waits
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // A done without a running task reports nothing but the status flag
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tdata_reg[44]) |-> (m_tdata_reg[43:0] == '0))
        else $error("status beat carries other fields");

endmodule

// ===== bench/ptrs_checker.sv =====
// Result checker for the periodic task release scheduler: predicts each result beat and compares it.
`timescale 1ns / 1ps

module ptrs_checker #(
    parameter int NUM_TASKS       = 3,
    parameter int HEARTBEAT_TICKS = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ptrs_pkg::ADDR_W-1:0]        paddr,
    input  logic [ptrs_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic [ptrs_pkg::APB_DATA_W-1:0]    prdata,
    input  logic                               pready,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // event_release, ui_hold, query_task[1:0], zeros
    input  logic [1:0]                         s_tuser,  // cmd[1:0]
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [47:0]                        m_tdata,  // task_valid, task_index[1:0], heartbeat,
                                                         // missed_count, executed_count, backlog,
                                                         // status, zeros
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 results_checked,
    output logic [ptrs_pkg::TIME_W-1:0]        tick_now
);

    import ptrs_pkg::*;

    // One result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0]            pad;
        logic                  status;
        logic [BACKLOG_W-1:0]  backlog;
        logic [CNT_W-1:0]      executed;
        logic [CNT_W-1:0]      missed;
        logic                  heartbeat;
        logic [TASK_IDX_W-1:0] task_index;
        logic                  task_valid;
    } sched_result_t;

    localparam logic [2:0] NO_TASK = 3'd7;

    // Predicted scheduler state
    logic [PERIOD_W-1:0]  period_reg_q [NUM_PERIOD_REGS];
    logic [TIME_W-1:0]    tick_q;
    logic [TIME_W-1:0]    release_at   [NUM_TASKS];
    logic [BACKLOG_W-1:0] jobs_waiting [NUM_TASKS];
    ptrs_task_state_t     task_st      [NUM_TASKS];
    logic [CNT_W-1:0]     missed_q     [NUM_TASKS];
    logic [CNT_W-1:0]     executed_q   [NUM_TASKS];
    logic [2:0]           running_q;

    sched_result_t expected_beats[$];

    int fail_total    = 0;
    int checked_total = 0;
    int pending_q     = 0;

    assign mismatches      = fail_total;
    assign results_checked = checked_total;
    assign outstanding     = pending_q;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(input string fname, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", fname, got, want));
    endtask

    task automatic restore_reset_state();
        for (int k = 0; k < NUM_PERIOD_REGS; k++)
            period_reg_q[k] = PERIOD_RESET[k];
        tick_q = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (i < NUM_PERIOD_REGS)
                release_at[i] = TIME_W'(period_reg_q[i]);
            else
                release_at[i] = '0;
            jobs_waiting[i] = 8'd1;
            task_st[i]      = TS_READY;
            missed_q[i]     = '0;
            executed_q[i]   = '0;
        end
        running_q = NO_TASK;
    endtask

    // Add one job to a task; a second waiting job means the deadline was missed
    task automatic post_job(input int t);
        if (jobs_waiting[t] != 8'hFF)
            jobs_waiting[t]++;
        if (task_st[t] != TS_RUNNING)
            task_st[t] = TS_READY;
        if (jobs_waiting[t] > 8'd1 && missed_q[t] != 16'hFFFF)
            missed_q[t]++;
    endtask

    task automatic load_counters(input int t, inout sched_result_t r);
        r.missed   = missed_q[t];
        r.executed = executed_q[t];
        r.backlog  = jobs_waiting[t];
    endtask

    // Advance the predicted state by one command beat and work out its result
    task automatic apply_command(input ptrs_cmd_t cmd, input logic ev, input logic hold,
                                 input logic [1:0] q, output sched_result_t r);
        logic found;
        int   t;
        r = '0;
        found = 1'b0;
        case (cmd)
            CMD_TICK:
            begin
                if (!hold)
                begin
                    for (int i = 0; i < NUM_TASKS - 1; i++)
                    begin
                        if (tick_q == release_at[i])
                        begin
                            if (i < NUM_PERIOD_REGS)
                                release_at[i] = tick_q + TIME_W'(period_reg_q[i]);
                            else
                                release_at[i] = tick_q;
                            post_job(i);
                        end
                    end
                    if (ev)
                        post_job(NUM_TASKS - 1);
                    tick_q = tick_q + 1;
                    r.heartbeat = ((tick_q % HEARTBEAT_TICKS) == 0);
                end
            end
            CMD_DISPATCH:
            begin
                if (running_q == NO_TASK)
                begin
                    for (int i = 0; i < NUM_TASKS; i++)
                    begin
                        if (!found && task_st[i] == TS_READY)
                        begin
                            task_st[i]   = TS_RUNNING;
                            running_q    = i[2:0];
                            r.task_valid = 1'b1;
                            r.task_index = i[1:0];
                            found        = 1'b1;
                        end
                    end
                end
            end
            CMD_DONE:
            begin
                if (running_q >= NUM_TASKS)
                    r.status = 1'b1;
                else
                begin
                    t = int'(running_q);
                    if (executed_q[t] != 16'hFFFF)
                        executed_q[t]++;
                    if (jobs_waiting[t] != 8'd0)
                        jobs_waiting[t]--;
                    if (jobs_waiting[t] != 8'd0)
                        task_st[t] = TS_READY;
                    else
                        task_st[t] = TS_BLOCKED;
                    running_q    = NO_TASK;
                    r.task_index = t[1:0];
                    load_counters(t, r);
                end
            end
            default:
            begin
                r.task_index = q;
                if (q < NUM_TASKS)
                    load_counters(int'(q), r);
            end
        endcase
    endtask

    task automatic compare_beats(input sched_result_t got, input sched_result_t want);
        check_field("task_valid",     got.task_valid, want.task_valid);
        check_field("task_index",     got.task_index, want.task_index);
        check_field("heartbeat",      got.heartbeat,  want.heartbeat);
        check_field("missed_count",   got.missed,     want.missed);
        check_field("executed_count", got.executed,   want.executed);
        check_field("backlog",        got.backlog,    want.backlog);
        check_field("status",         got.status,     want.status);
        check_field("padding",        got.pad,        want.pad);
    endtask

    // Watch the register port and both streams at every rising edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        sched_result_t       want;
        sched_result_t       got;
        logic [REG_IDX_W-1:0] reg_idx;
        if (!rst_n)
        begin
            restore_reset_state();
            expected_beats.delete();
            pending_q <= 0;
            tick_now  <= '0;
        end
        else
        begin
            // Register writes and read-back
            if (psel && penable && pready)
            begin
                reg_idx = paddr[ADDR_W-1:2];
                if (pwrite)
                begin
                    if (reg_idx < NUM_PERIOD_REGS)
                    begin
                        period_reg_q[reg_idx] = pwdata[PERIOD_W-1:0];
                        if (reg_idx < NUM_TASKS)
                            release_at[reg_idx] = TIME_W'(pwdata[PERIOD_W-1:0]);
                    end
                end
                else if (reg_idx < NUM_PERIOD_REGS)
                    check_field($sformatf("period register %0d read-back", reg_idx),
                                prdata[PERIOD_W-1:0], period_reg_q[reg_idx]);
            end
            // Command beat accepted: predict its result
            if (s_tvalid && s_tready)
            begin
                apply_command(ptrs_cmd_t'(s_tuser), s_tdata[0], s_tdata[1], s_tdata[3:2], want);
                expected_beats.push_back(want);
            end
            // Result beat accepted: compare with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = sched_result_t'(m_tdata);
                if (expected_beats.size() == 0)
                    report_mismatch($sformatf("result beat 0x%h with no command outstanding",
                                              m_tdata));
                else
                begin
                    want = expected_beats.pop_front();
                    compare_beats(got, want);
                    checked_total++;
                end
            end
            pending_q <= expected_beats.size();
            tick_now  <= tick_q;
        end
    end

endmodule

// ===== bench/tb_periodic_task_release_scheduler.sv =====
// Testbench top for the periodic task release scheduler: clock, stimulus phases and verdict.
`timescale 1ns / 1ps

module tb_periodic_task_release_scheduler;

    import ptrs_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int SAT_TICKS      = 260;

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [ADDR_W-1:0]       paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata  = '0;  // event_release, ui_hold, query_task[1:0], zeros
    logic [1:0]              s_tuser  = '0;  // cmd[1:0]
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [47:0]             m_tdata;        // task_valid, task_index[1:0], heartbeat,
                                             // missed_count, executed_count, backlog, status

    int                      mismatches;
    int                      outstanding;
    int                      results_checked;
    logic [TIME_W-1:0]       tick_now;

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int holdoff_asks   = 0;
    int holdoff_served = 0;
    int holdoff_left   = 0;
    int beats_sent     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    periodic_task_release_scheduler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ptrs_checker sched_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .tick_now        (tick_now)
    );

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            m_tready     <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoff_served != holdoff_asks)
        begin
            m_tready       <= 1'b0;
            holdoff_left   <= HOLDOFF_CYCLES;
            holdoff_served <= holdoff_asks;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Give up if the run hangs
    initial
    begin
        #15_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [REG_IDX_W-1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_periods();
        apb_read(REG_PERIOD0);
        apb_read(REG_PERIOD1);
        apb_read(REG_PERIOD2);
    endtask

    // Offer one command beat and hold it until accepted; valid stays high afterwards
    task automatic push_beat(input ptrs_cmd_t cmd, input logic ev, input logic hold,
                             input logic [1:0] q);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, q, hold, ev};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random command mix; held ticks are not counted
    task automatic run_random(input int count);
        int        sent;
        int        pick;
        ptrs_cmd_t cmd;
        logic      ev;
        logic      hold;
        logic [1:0] q;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = CMD_TICK;
            else if (pick < 65)
                cmd = CMD_DISPATCH;
            else if (pick < 90)
                cmd = CMD_DONE;
            else
                cmd = CMD_QUERY;
            ev   = 1'($urandom_range(0, 1));
            hold = ($urandom_range(0, 99) < 15);
            q    = 2'($urandom_range(0, 3));
            push_beat(cmd, ev, hold, q);
            if (!(cmd == CMD_TICK && hold))
                sent++;
            sender_gap();
        end
    endtask

    initial
    begin : stimulus
        int wait_cycles;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, every command, the corner cases at the table edges
        read_periods();
        push_beat(CMD_QUERY,    1'b0, 1'b0, 2'd0);
        push_beat(CMD_QUERY,    1'b0, 1'b0, 2'd3);  // index past the last task
        push_beat(CMD_DONE,     1'b0, 1'b0, 2'd0);  // nothing running
        push_beat(CMD_DISPATCH, 1'b0, 1'b0, 2'd0);
        push_beat(CMD_DISPATCH, 1'b0, 1'b0, 2'd0);  // already running
        push_beat(CMD_TICK,     1'b1, 1'b1, 2'd0);  // held tick
        push_beat(CMD_TICK,     1'b1, 1'b0, 2'd0);  // event release
        push_beat(CMD_DONE,     1'b0, 1'b0, 2'd0);
        push_beat(CMD_DONE,     1'b0, 1'b0, 2'd0);
        push_beat(CMD_DISPATCH, 1'b0, 1'b0, 2'd0);
        push_beat(CMD_DONE,     1'b0, 1'b0, 2'd0);
        push_beat(CMD_DISPATCH, 1'b0, 1'b0, 2'd0);
        push_beat(CMD_QUERY,    1'b1, 1'b1, 2'd2);
        push_beat(CMD_DONE,     1'b0, 1'b0, 2'd0);
        push_beat(CMD_DISPATCH, 1'b0, 1'b0, 2'd0);
        push_beat(CMD_DONE,     1'b0, 1'b0, 2'd0);
        push_beat(CMD_DISPATCH, 1'b0, 1'b0, 2'd0);  // nothing ready
        push_beat(CMD_QUERY,    1'b1, 1'b0, 2'd1);
        push_beat(CMD_QUERY,    1'b0, 1'b1, 2'd2);
        drain();

        // Shortest periods while the tick count is still low, no idling
        apb_write(REG_PERIOD0, 32'd1);
        apb_write(REG_PERIOD1, 32'd3);
        apb_write(REG_PERIOD2, 32'hA5C3_FFFF);      // upper bits must be dropped
        apb_write(REG_SPARE,   32'd77);
        read_periods();
        run_random(60);
        drain();

        // Sender idles
        apb_write(REG_PERIOD0, 32'd65535);
        apb_write(REG_PERIOD1, {16'h0000, tick_now[15:0] + 16'd2});
        apb_write(REG_PERIOD2, 32'd1);
        read_periods();
        tx_idle_pct = 56;
        run_random(60);
        drain();

        // Receiver stalls; a late period and a zero period
        apb_write(REG_PERIOD0, {16'h0000, tick_now[15:0]});
        apb_write(REG_PERIOD1, {16'h0000, tick_now[15:0] >> 1});
        apb_write(REG_PERIOD2, 32'd0);
        read_periods();
        tx_idle_pct = 0;
        rx_stall_pct <= 56;
        run_random(60);
        drain();

        // Back-pressure: long receiver hold-off while beats keep coming, then both idle
        apb_write(REG_PERIOD0, {16'h0000, tick_now[15:0] + 16'($urandom_range(1, 6))});
        apb_write(REG_PERIOD1, {16'h0000, tick_now[15:0] + 16'($urandom_range(1, 6))});
        apb_write(REG_PERIOD2, {16'h0000, 16'($urandom_range(1, 65535))});
        read_periods();
        rx_stall_pct <= 0;
        holdoff_asks <= holdoff_asks + 1;
        run_random(20);
        tx_idle_pct = 35;
        rx_stall_pct <= 35;
        run_random(40);
        drain();

        // Saturation: park the periodic tasks, then flood the event task
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        apb_write(REG_PERIOD0, 32'd1);
        apb_write(REG_PERIOD1, 32'd1);
        read_periods();
        repeat (SAT_TICKS)
            push_beat(CMD_TICK, 1'b1, 1'b0, 2'd0);
        push_beat(CMD_QUERY, 1'b0, 1'b0, 2'd0);
        push_beat(CMD_QUERY, 1'b0, 1'b0, 2'd1);
        push_beat(CMD_QUERY, 1'b0, 1'b0, 2'd2);
        push_beat(CMD_QUERY, 1'b0, 1'b0, 2'd3);
        s_tvalid <= 1'b0;

        // Let the last results out, with a bound
        @(posedge clk);
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (8) @(posedge clk);

        if (outstanding != 0)
            $display("ERROR: %0d results never arrived", outstanding);
        $display("Sent %0d command beats over directed, idle, stall, hold-off and saturation phases",
                 beats_sent);
        $display("Compared %0d result beats; final tick count %0d", results_checked, tick_now);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
